FILE: hw/rtl/blkavg_pkg.sv
// ----------------------------------------------------------------------------
// blkavg_pkg
// Types, codes and constants shared by the block average downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package blkavg_pkg;

    localparam int DEF_MAX_WIDTH        = 2048;
    localparam int DEF_MAX_BLOCK_HEIGHT = 1024;

    localparam int CH_W   = 8;
    localparam int CFG_W  = 12;
    localparam int BHC_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_BLOCK_WIDTH  = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_BLOCK_HEIGHT = IDX_W'(2);

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd2048;
    localparam logic [CFG_W-1:0] BLOCK_WIDTH_RST  = 12'd1;
    localparam logic [BHC_W-1:0] BLOCK_HEIGHT_RST = 11'd1;

    typedef enum logic [2:0] {
        KIND_SAME      = 3'd0,
        KIND_RESET     = 3'd1,
        KIND_NEW       = 3'd2,
        KIND_ROW_END   = 3'd3,
        KIND_ROW_RESET = 3'd4
    } kind_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        kind_t           kind;
        logic [CH_W-1:0] avg_red;
        logic [CH_W-1:0] avg_green;
        logic [CH_W-1:0] avg_blue;
        logic            last;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_ACC,
        ST_DIV,
        ST_EMIT_BLK,
        ST_EMIT_ROW
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic take;
        logic acc;
        logic div_load;
        logic div_mod;
        logic div_step;
        logic emit_blk;
        logic emit_row;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic dirty;
        logic blk_now;
        logic rowe_now;
        logic rowe_hold;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/block_average_downscaler.sv
// ----------------------------------------------------------------------------
// block_average_downscaler
// Box filter downsampler: per-column band sums, block averages, row ends.
// Ordinary pixel: accept (column sum read), then accumulate, then back to idle;
//   pixel_stall stays high until it is back in idle. Block end: a bit-serial divider
//   pass, then the block result, then a row end result when one follows.
// First pixel after a block_width write adds the same divider pass (column phase).
// Reset: column sum memory is cleared one entry a cycle, all MAX_WIDTH entries,
//   pixel_stall high meanwhile; config writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_downscaler
    import blkavg_pkg::*;
#(
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_BLOCK_HEIGHT = DEF_MAX_BLOCK_HEIGHT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             pixel_valid,
    output logic                  pixel_stall,
    input  wire pixel_t           pixel,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    blkavg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .dp_stat     (dp_stat),
        .pixel_stall (pixel_stall),
        .cmd         (cmd)
    );

    blkavg_dpath #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_BLOCK_HEIGHT (MAX_BLOCK_HEIGHT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .result_stall (result_stall),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_blk_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_blk |-> dp_stat.out_free)
        else $error("block result loaded over a pending result");

    a_row_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_row |-> dp_stat.out_free)
        else $error("row result loaded over a pending result");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> pixel_stall)
        else $error("second item taken before the first was processed");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> cmd.div_step)
        else $error("divider loaded but not stepped");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/blkavg_div.sv
// ----------------------------------------------------------------------------
// blkavg_div
// Restoring divider lane, one quotient bit per step; keeps low quotient byte.
// ----------------------------------------------------------------------------
`default_nettype none

module blkavg_div
    import blkavg_pkg::*;
#(
    parameter int DVD_W = 29,
    parameter int DSR_W = 23
)
(
    input  wire logic             clk,
    input  wire logic             load,
    input  wire logic             step,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic      [CH_W-1:0]  quot,
    output logic      [DSR_W-1:0] rem
);

    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [CH_W-1:0]  quot_reg;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (step)
        begin
            dvd_reg  <= dvd_reg << 1;
            rem_reg  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quot_reg <= {quot_reg[CH_W-2:0], ge};
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/blkavg_ctrl.sv
// ----------------------------------------------------------------------------
// blkavg_ctrl
// Sequencer: column sum clear, accumulate, divide and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module blkavg_ctrl
    import blkavg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    input  wire dp_status_t dp_stat,
    output logic            pixel_stall,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        pixel_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (dp_stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                pixel_stall = 1'b0;
                if (pixel_valid)
                begin
                    cmd.take = 1'b1;
                    if (dp_stat.dirty)
                    begin
                        cmd.div_load = 1'b1;
                        cmd.div_mod  = 1'b1;
                        state_next   = ST_MOD;
                    end
                    else
                        state_next = ST_ACC;
                end
            end
            ST_MOD:
            begin
                cmd.div_step = 1'b1;
                if (dp_stat.div_last)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (dp_stat.blk_now)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
                else if (dp_stat.rowe_now)
                    state_next = ST_EMIT_ROW;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (dp_stat.div_last)
                    state_next = ST_EMIT_BLK;
            end
            ST_EMIT_BLK:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.emit_blk = 1'b1;
                    state_next   = dp_stat.rowe_hold ? ST_EMIT_ROW : ST_IDLE;
                end
            end
            ST_EMIT_ROW:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/blkavg_dpath.sv
// ----------------------------------------------------------------------------
// blkavg_dpath
// Config registers, column sum memory, block run sums, dividers, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module blkavg_dpath
    import blkavg_pkg::*;
#(
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_BLOCK_HEIGHT = DEF_MAX_BLOCK_HEIGHT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire pixel_t           pixel,
    input  wire logic             result_stall,
    input  wire ctrl_cmd_t        cmd,
    output dp_status_t            dp_stat,
    output logic                  result_valid,
    output result_t               result
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_BLOCK_HEIGHT > 1) ? $clog2(MAX_BLOCK_HEIGHT) : 1;
    localparam int BH_W   = $clog2(MAX_BLOCK_HEIGHT + 1);
    localparam int CSUM_W = CH_W + $clog2(MAX_BLOCK_HEIGHT);
    localparam int RUN_W  = CSUM_W + $clog2(MAX_WIDTH);
    localparam int DIV_W  = CFG_W + BH_W;
    localparam int CNT_W  = $clog2(RUN_W);

    // config
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] block_width_reg;
    logic [BHC_W-1:0] block_height_reg;
    logic             dirty_reg;

    // stream position
    logic [COL_W-1:0] column_index_reg;
    logic [ROW_W-1:0] band_row_reg;
    logic [COL_W-1:0] bpos_reg;
    logic [COL_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0] cnt_reg;

    // payload
    pixel_t                      pixel_reg;
    logic [2:0][CSUM_W-1:0]      csum_mem [MAX_WIDTH];
    logic [2:0][CSUM_W-1:0]      rdata_reg;
    logic [RUN_W-1:0]            run_reg  [3];
    logic [DIV_W-1:0]            div_reg;
    logic [3*CH_W-1:0]           prev_reg;
    logic                        rowe_reg;
    logic                        out_valid_reg;
    result_t                     out_reg;

    logic [31:0]                 w_eff;
    logic [31:0]                 bh_eff32;
    logic [BH_W-1:0]             bh_eff;
    logic [CFG_W-1:0]            bw_eff;
    logic [COL_W-1:0]            bpos_cur;
    logic                        row_end;
    logic                        last_row;
    logic                        block_end;
    logic [CH_W-1:0]             pix_ch   [3];
    logic [2:0][CSUM_W-1:0]      newsum;
    logic [RUN_W-1:0]            run_next [3];
    logic [RUN_W-1:0]            lane_dvd [3];
    logic [DIV_W-1:0]            lane_dsr;
    logic [CH_W-1:0]             quot     [3];
    logic [DIV_W-1:0]            rem_red;
    logic [3*CH_W-1:0]           colour;
    logic                        out_free;
    logic                        mem_we;
    logic [COL_W-1:0]            mem_addr;
    logic [2:0][CSUM_W-1:0]      mem_wdata;

    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = 32'd1;
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_eff = 32'(MAX_WIDTH);
        else
            w_eff = 32'(image_width_reg);

        if (block_height_reg == '0)
            bh_eff32 = 32'd1;
        else if (32'(block_height_reg) > 32'(MAX_BLOCK_HEIGHT))
            bh_eff32 = 32'(MAX_BLOCK_HEIGHT);
        else
            bh_eff32 = 32'(block_height_reg);
        bh_eff = BH_W'(bh_eff32);

        bw_eff = (block_width_reg == '0) ? CFG_W'(1) : block_width_reg;

        // after a block_width change the column phase comes from the divider
        bpos_cur  = dirty_reg ? COL_W'(rem_red) : bpos_reg;
        row_end   = (32'(column_index_reg) + 32'd1) >= w_eff;
        last_row  = (32'(band_row_reg) + 32'd1) >= bh_eff32;
        block_end = (32'(bpos_cur) + 32'd1) == 32'(bw_eff);

        pix_ch[0] = pixel_reg.red;
        pix_ch[1] = pixel_reg.green;
        pix_ch[2] = pixel_reg.blue;
        for (int c = 0; c < 3; c++)
        begin
            newsum[c]   = rdata_reg[c] + CSUM_W'(pix_ch[c]);
            run_next[c] = last_row ? run_reg[c] + RUN_W'(newsum[c]) : run_reg[c];
            lane_dvd[c] = cmd.div_mod ? RUN_W'(column_index_reg) : run_next[c];
        end
        lane_dsr = cmd.div_mod ? DIV_W'(bw_eff) : div_reg;
        colour   = {quot[0], quot[1], quot[2]};
        out_free = !out_valid_reg || !result_stall;

        mem_we    = cmd.clr_wr || cmd.acc;
        mem_addr  = cmd.clr_wr ? clr_addr_reg : column_index_reg;
        mem_wdata = (cmd.clr_wr || last_row) ? '0 : newsum;
    end

    blkavg_div #(.DVD_W(RUN_W), .DSR_W(DIV_W)) u_div_red (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (lane_dvd[0]),
        .divisor  (lane_dsr),
        .quot     (quot[0]),
        .rem      (rem_red)
    );

    blkavg_div #(.DVD_W(RUN_W), .DSR_W(DIV_W)) u_div_green (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (lane_dvd[1]),
        .divisor  (lane_dsr),
        .quot     (quot[1]),
        .rem      ()
    );

    blkavg_div #(.DVD_W(RUN_W), .DSR_W(DIV_W)) u_div_blue (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (lane_dvd[2]),
        .divisor  (lane_dsr),
        .quot     (quot[2]),
        .rem      ()
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            csum_mem[mem_addr] <= mem_wdata;
        if (cmd.take)
            rdata_reg <= csum_mem[column_index_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            block_width_reg  <= BLOCK_WIDTH_RST;
            block_height_reg <= BLOCK_HEIGHT_RST;
            dirty_reg        <= 1'b0;
            column_index_reg <= '0;
            band_row_reg     <= '0;
            bpos_reg         <= '0;
            clr_addr_reg     <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            prev_reg         <= '0;
            for (int c = 0; c < 3; c++)
                run_reg[c] <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_addr_reg <= clr_addr_reg + COL_W'(1);

            if (cmd.div_load)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + CNT_W'(1);

            if (cmd.acc)
            begin
                dirty_reg <= 1'b0;
                for (int c = 0; c < 3; c++)
                    run_reg[c] <= run_next[c];
                if (row_end)
                begin
                    column_index_reg <= '0;
                    bpos_reg         <= '0;
                    band_row_reg     <= last_row ? '0 : band_row_reg + ROW_W'(1);
                end
                else
                begin
                    column_index_reg <= column_index_reg + COL_W'(1);
                    bpos_reg         <= block_end ? '0 : bpos_cur + COL_W'(1);
                end
            end

            if (cmd.emit_blk)
            begin
                prev_reg <= colour;
                for (int c = 0; c < 3; c++)
                    run_reg[c] <= '0;
            end
            if (cmd.emit_row)
            begin
                prev_reg <= '0;
                for (int c = 0; c < 3; c++)
                    run_reg[c] <= '0;
            end

            if (cmd.emit_blk || cmd.emit_row)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_width_reg <= cfg_data;
                    CFG_BLOCK_WIDTH:
                    begin
                        block_width_reg <= cfg_data;
                        dirty_reg       <= 1'b1;
                    end
                    CFG_BLOCK_HEIGHT: block_height_reg <= cfg_data[BHC_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pixel_reg <= pixel;
            div_reg   <= DIV_W'(bw_eff) * DIV_W'(bh_eff);
        end
        if (cmd.acc)
            rowe_reg <= last_row && row_end;
        if (cmd.emit_blk)
        begin
            if (colour == prev_reg)
                out_reg.kind <= KIND_SAME;
            else if (colour == '0)
                out_reg.kind <= KIND_RESET;
            else
                out_reg.kind <= KIND_NEW;
            out_reg.avg_red   <= quot[0];
            out_reg.avg_green <= quot[1];
            out_reg.avg_blue  <= quot[2];
            out_reg.last      <= !rowe_reg;
        end
        else if (cmd.emit_row)
        begin
            out_reg.kind      <= (prev_reg != '0) ? KIND_ROW_RESET : KIND_ROW_END;
            out_reg.avg_red   <= '0;
            out_reg.avg_green <= '0;
            out_reg.avg_blue  <= '0;
            out_reg.last      <= 1'b1;
        end
    end

    always_comb
    begin
        dp_stat.clr_last  = clr_addr_reg == COL_W'(MAX_WIDTH - 1);
        dp_stat.dirty     = dirty_reg;
        dp_stat.blk_now   = last_row && block_end;
        dp_stat.rowe_now  = last_row && row_end;
        dp_stat.rowe_hold = rowe_reg;
        dp_stat.div_last  = cnt_reg == CNT_W'(RUN_W - 1);
        dp_stat.out_free  = out_free;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for block_average_downscaler. A clocked driver feeds pixels from a
// queue with random gaps; a clocked monitor predicts the block averages and
// row ends of every accepted item and checks each result against them.
// ----------------------------------------------------------------------------
module tb;
    import blkavg_pkg::*;

    localparam int ITEMS        = 850;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_LIMIT   = 10000;
    localparam int HOLDOFF      = 300;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_write    = 1'b0;
    logic [IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0] cfg_data     = '0;
    logic             pixel_valid  = 1'b0;
    logic             pixel_stall;
    pixel_t           pixel        = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;

    pixel_t  pixel_queue [$];
    result_t pending_results [$];

    // predictor state
    logic [CFG_W-1:0] cur_image_width  = IMAGE_WIDTH_RST;
    logic [CFG_W-1:0] cur_block_width  = BLOCK_WIDTH_RST;
    logic [BHC_W-1:0] cur_block_height = BLOCK_HEIGHT_RST;
    int unsigned      col_sum [DEF_MAX_WIDTH][3] = '{default: 0};
    int unsigned      band_row     = 0;
    int unsigned      column_index = 0;
    longint unsigned  run_sum [3]  = '{0, 0, 0};
    logic [23:0]      prev_colour  = '0;

    // pixel generation
    bit     flat_paint = 1'b0;
    pixel_t paint      = '0;
    pixel_t tone_a     = '0;
    pixel_t tone_b     = '0;

    bit pixel_taken  = 1'b0;
    bit result_taken = 1'b0;
    int pixel_wait   = 0;
    int pixel_burst  = 0;
    int result_wait  = 0;
    int result_burst = 0;
    int stall_hold   = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    block_average_downscaler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void downscale_pixel(pixel_t p);
        int unsigned     w;
        int unsigned     bw;
        int unsigned     bh;
        int unsigned     col;
        longint unsigned div;
        logic [7:0]      avg [3];
        logic [23:0]     colour;
        logic            last_row;
        logic            row_end;
        result_t         outs [2];
        int              n;
        n = 0;
        w = (cur_image_width == 0) ? 1 :
            (cur_image_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_image_width;
        bw = (cur_block_width == 0) ? 1 : cur_block_width;
        bh = (cur_block_height == 0) ? 1 :
             (cur_block_height > DEF_MAX_BLOCK_HEIGHT) ? DEF_MAX_BLOCK_HEIGHT : cur_block_height;
        col = column_index % DEF_MAX_WIDTH;
        last_row = (band_row + 1) >= bh;
        row_end = (col + 1) >= w;

        col_sum[col][0] += p.red;
        col_sum[col][1] += p.green;
        col_sum[col][2] += p.blue;

        if (last_row)
        begin
            for (int c = 0; c < 3; c++)
            begin
                run_sum[c] += col_sum[col][c];
                col_sum[col][c] = 0;
            end
            if (((col + 1) % bw) == 0)
            begin
                div = longint'(bw) * longint'(bh);
                for (int c = 0; c < 3; c++)
                    avg[c] = 8'(run_sum[c] / div);
                colour = {avg[0], avg[1], avg[2]};
                outs[n].kind = (colour == prev_colour) ? KIND_SAME :
                               (colour == 24'd0) ? KIND_RESET : KIND_NEW;
                outs[n].avg_red = avg[0];
                outs[n].avg_green = avg[1];
                outs[n].avg_blue = avg[2];
                outs[n].last = 1'b0;
                n++;
                prev_colour = colour;
                run_sum = '{0, 0, 0};
            end
            if (row_end)
            begin
                outs[n].kind = (prev_colour != 24'd0) ? KIND_ROW_RESET : KIND_ROW_END;
                outs[n].avg_red = '0;
                outs[n].avg_green = '0;
                outs[n].avg_blue = '0;
                outs[n].last = 1'b0;
                n++;
                prev_colour = '0;
                run_sum = '{0, 0, 0};
            end
        end

        if (row_end)
        begin
            column_index = 0;
            band_row = last_row ? 0 : band_row + 1;
        end
        else
            column_index = col + 1;

        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results.push_back(outs[i]);
    endfunction

    function automatic pixel_t next_pixel();
        pixel_t px;
        if (!flat_paint)
        begin
            case ($urandom_range(0, 7))
                0:       px = '0;
                1:       px = '1;
                default: px = 24'($urandom);
            endcase
        end
        else
        begin
            // runs of a few colours so whole blocks repeat or go black
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       paint = '0;
                    1:       paint = '1;
                    2:       paint = tone_a;
                    default: paint = tone_b;
                endcase
            end
            px = paint;
        end
        return px;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || pixel_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_queue.push_back({r, g, b});
    endtask

    always @(negedge clk)
    begin : pixel_driver
        if (rst_n && !(pixel_valid && !pixel_taken))
        begin
            if (pixel_taken)
            begin
                pixel_taken = 1'b0;
                if (pixel_burst > 0)
                begin
                    pixel_burst--;
                    pixel_wait = 0;
                end
                else
                begin
                    pixel_wait = $urandom_range(0, 5);
                    if ($urandom_range(0, 15) == 0)
                        pixel_burst = $urandom_range(8, 40);
                end
            end
            if (pixel_wait > 0)
            begin
                pixel_wait--;
                pixel_valid <= 1'b0;
            end
            else if (pixel_queue.size() != 0)
            begin
                pixel <= pixel_queue.pop_front();
                pixel_valid <= 1'b1;
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : result_receiver
        if (stall_hold > 0)
        begin
            stall_hold--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                if (result_burst > 0)
                begin
                    result_burst--;
                    result_wait = 0;
                end
                else
                begin
                    result_wait = $urandom_range(0, 5);
                    if ($urandom_range(0, 15) == 0)
                        result_burst = $urandom_range(8, 40);
                end
            end
            if (result_wait > 0)
            begin
                if (result_valid)
                    result_wait--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  cur_image_width = cfg_data;
                CFG_BLOCK_WIDTH:  cur_block_width = cfg_data;
                CFG_BLOCK_HEIGHT: cur_block_height = cfg_data[BHC_W-1:0];
                default: ;
            endcase
        end
        if (pixel_valid && !pixel_stall)
        begin
            downscale_pixel(pixel);
            pixel_taken = 1'b1;
        end
        if (result_valid && !result_stall)
        begin
            result_taken = 1'b1;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d avg %0d %0d %0d last %0b",
                             result.kind, result.avg_red, result.avg_green,
                             result.avg_blue, result.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.kind !== want.kind || result.avg_red !== want.avg_red ||
                    result.avg_green !== want.avg_green ||
                    result.avg_blue !== want.avg_blue || result.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d avg %0d %0d %0d last %0b, got kind %0d avg %0d %0d %0d last %0b",
                                 want.kind, want.avg_red, want.avg_green, want.avg_blue,
                                 want.last, result.kind, result.avg_red, result.avg_green,
                                 result.avg_blue, result.last);
                end
            end
        end
        if (cfg_write || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else if (++idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int               sent;
        int               phase;
        int               phase_items;
        logic [CFG_W-1:0] iw;
        logic [CFG_W-1:0] bw;
        logic [BHC_W-1:0] bh;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wide row, one-pixel blocks: same, new, back to black
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd0, 8'd128);
        push_pixel(8'd255, 8'd0, 8'd128);
        wait_idle();

        // zero width: column index past the row's end closes the row
        write_reg(CFG_IMAGE_WIDTH, 12'd0);
        push_pixel(8'd10, 8'd20, 8'd30);
        push_pixel(8'd0, 8'd0, 8'd0);
        wait_idle();

        // tallest band and block wider than row, then band cut short
        write_reg(CFG_BLOCK_HEIGHT, 12'h7FF);
        write_reg(CFG_BLOCK_WIDTH, 12'hFFF);
        repeat (4) push_pixel(8'd255, 8'd255, 8'd255);
        wait_idle();
        write_reg(CFG_BLOCK_HEIGHT, 12'd3);
        push_pixel(8'd255, 8'd255, 8'd255);
        wait_idle();

        write_reg(CFG_BLOCK_WIDTH, 12'd0);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        wait_idle();

        // widest row, then width shrunk so leftover columns are dropped
        write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
        write_reg(CFG_BLOCK_WIDTH, 12'd2);
        write_reg(CFG_BLOCK_HEIGHT, 12'd1);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd1, 8'd2, 8'd3);
        push_pixel(8'd200, 8'd100, 8'd50);
        push_pixel(8'd200, 8'd100, 8'd50);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        push_pixel(8'd77, 8'd88, 8'd99);

        sent = 20;
        phase = 0;
        while (sent < ITEMS)
        begin
            // sender pauses here until every result is in
            wait_idle();
            if (phase == 3)
            begin
                write_reg(CFG_IMAGE_WIDTH, 12'd4);
                write_reg(CFG_BLOCK_WIDTH, 12'd1);
                write_reg(CFG_BLOCK_HEIGHT, 12'd1);
                phase_items = 80;
            end
            else
            begin
                iw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 4095))
                                                 : CFG_W'($urandom_range(1, 16));
                if ($urandom_range(0, 7) == 0)
                    bw = ($urandom_range(0, 1) == 0) ? '0 : CFG_W'(iw + $urandom_range(1, 8));
                else
                    bw = CFG_W'($urandom_range(1, (iw == 0) ? 1 : iw));
                bh = ($urandom_range(0, 9) == 0) ? BHC_W'($urandom_range(0, 2047))
                                                 : BHC_W'($urandom_range(1, 4));
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_IMAGE_WIDTH, iw);
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_BLOCK_WIDTH, bw);
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_BLOCK_HEIGHT, CFG_W'(bh));
                phase_items = $urandom_range(10, 60);
            end
            flat_paint = ($urandom_range(0, 4) < 3);
            tone_a = 24'($urandom);
            tone_b = 24'($urandom);
            paint = tone_a;
            repeat (phase_items) pixel_queue.push_back(next_pixel());
            // receiver holds off while the sender keeps offering
            if (phase == 3)
                stall_hold = HOLDOFF;
            sent += phase_items;
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: block_average_downscaler.f
hw/rtl/blkavg_pkg.sv
hw/rtl/blkavg_div.sv
hw/rtl/blkavg_ctrl.sv
hw/rtl/blkavg_dpath.sv
hw/rtl/block_average_downscaler.sv
sim/tb.sv
